>>> sv/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants for the gate relay sequencer
// Payload structs, state codes, command codes and register defaults.
// ----------------------------------------------------------------------------
package grs_pkg;

   localparam int TimeW  = 32;
   localparam int LimitW = 16;
   localparam int CountW = 8;
   localparam int CsrIdxW = 2;

   localparam logic [LimitW-1:0] OpenTimeReset  = 16'd20000;
   localparam logic [LimitW-1:0] CloseTimeReset = 16'd15000;
   localparam logic [LimitW-1:0] CooldownReset  = 16'd1000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_OPEN_TIME  = 2'd0,
      CSR_CLOSE_TIME = 2'd1,
      CSR_COOLDOWN   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_NOOP  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_CLOSE = 2'd2,
      CMD_PING  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      GATE_IDLE    = 2'd0,
      GATE_OPENING = 2'd1,
      GATE_CLOSING = 2'd2
   } gate_state_type;

   typedef enum logic [1:0] {
      BTN_READY = 2'd0,
      BTN_OPEN  = 2'd1,
      BTN_CLOSE = 2'd2
   } button_state_type;

   typedef struct packed {
      logic [TimeW-1:0] now_ms;
      logic             open_button_level;
      logic             close_button_level;
      logic             packet_received;
      logic [1:0]       command;
   } req_payload_type;

   typedef struct packed {
      logic              relay_open_on;
      logic              relay_close_on;
      logic [1:0]        gate_phase;
      logic [1:0]        button_phase;
      logic [CountW-1:0] packet_count;
      logic              ack_due;
   } rsp_payload_type;

   // accepted presses from the button machine
   typedef struct packed {
      logic open_pressed;
      logic close_pressed;
   } press_type;

   // open/close requests seen by the gate machine
   typedef struct packed {
      logic open_req;
      logic close_req;
   } gate_event_type;

   typedef struct packed {
      logic relay_open_on;
      logic relay_close_on;
   } relay_type;

   // wrap-safe elapsed time check
   function automatic logic timer_expired(logic [TimeW-1:0] now,
                                          logic [TimeW-1:0] start,
                                          logic [LimitW-1:0] limit);
      logic [TimeW-1:0] elapsed;
      elapsed = now - start;
      return elapsed >= {{(TimeW-LimitW){1'b0}}, limit};
   endfunction

endpackage

>>> sv/grs_button_fsm.sv
// ----------------------------------------------------------------------------
// grs_button_fsm: button press acceptance with cooldown
// Accepts one press (open first) and ignores the buttons until cooldown ends.
// ----------------------------------------------------------------------------
module grs_button_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [grs_pkg::TimeW-1:0]     now_ms,
   input  logic                          open_low,
   input  logic                          close_low,
   input  logic [grs_pkg::LimitW-1:0]    cooldown_ms,
   output grs_pkg::press_type            press,
   output logic [1:0]                    button_phase
);

   grs_pkg::button_state_type state_ff, state_in;
   logic [grs_pkg::TimeW-1:0] start_ff, start_in;
   logic                      expired;

   assign expired = grs_pkg::timer_expired(now_ms, start_ff, cooldown_ms);

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      case (state_ff)
         grs_pkg::BTN_OPEN, grs_pkg::BTN_CLOSE: begin
            if (expired) begin
               state_in = grs_pkg::BTN_READY;
               start_in = now_ms;
            end
         end
         default: begin
            if (open_low) begin
               state_in = grs_pkg::BTN_OPEN;
               start_in = now_ms;
            end else if (close_low) begin
               state_in = grs_pkg::BTN_CLOSE;
               start_in = now_ms;
            end else begin
               state_in = grs_pkg::BTN_READY;
            end
         end
      endcase
   end

   always_comb begin
      press = '0;
      case (state_ff)
         grs_pkg::BTN_OPEN, grs_pkg::BTN_CLOSE: begin
            press = '0;
         end
         default: begin
            press.open_pressed  = open_low;
            press.close_pressed = !open_low && close_low;
         end
      endcase
      button_phase = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grs_pkg::BTN_READY;
         start_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

endmodule

>>> sv/grs_gate_fsm.sv
// ----------------------------------------------------------------------------
// grs_gate_fsm: gate motion state machine
// Idle -> opening/closing on a request; back to idle on timeout or request.
// ----------------------------------------------------------------------------
module grs_gate_fsm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [grs_pkg::TimeW-1:0]     now_ms,
   input  grs_pkg::gate_event_type       gate_event,
   input  logic [grs_pkg::LimitW-1:0]    open_time_ms,
   input  logic [grs_pkg::LimitW-1:0]    close_time_ms,
   output grs_pkg::relay_type            relay,
   output logic [1:0]                    gate_phase
);

   grs_pkg::gate_state_type   state_ff, state_in;
   logic [grs_pkg::TimeW-1:0] start_ff, start_in;
   logic [grs_pkg::LimitW-1:0] limit;
   logic                      expired;
   logic                      any_event;

   assign limit     = (state_ff == grs_pkg::GATE_OPENING) ? open_time_ms : close_time_ms;
   assign expired   = grs_pkg::timer_expired(now_ms, start_ff, limit);
   assign any_event = gate_event.open_req || gate_event.close_req;

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      case (state_ff)
         grs_pkg::GATE_OPENING, grs_pkg::GATE_CLOSING: begin
            if (expired || any_event) begin
               state_in = grs_pkg::GATE_IDLE;
               start_in = now_ms;
            end
         end
         default: begin
            if (gate_event.open_req) begin
               state_in = grs_pkg::GATE_OPENING;
               start_in = now_ms;
            end else if (gate_event.close_req) begin
               state_in = grs_pkg::GATE_CLOSING;
               start_in = now_ms;
            end else begin
               state_in = grs_pkg::GATE_IDLE;
            end
         end
      endcase
   end

   // relays follow the state held before this pass
   always_comb begin
      relay.relay_open_on  = (state_ff == grs_pkg::GATE_OPENING);
      relay.relay_close_on = (state_ff == grs_pkg::GATE_CLOSING);
      gate_phase           = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grs_pkg::GATE_IDLE;
         start_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

endmodule

>>> sv/gate_relay_sequencer_top.sv
// ----------------------------------------------------------------------------
// gate_relay_sequencer_top: two-relay gate controller, one pass per item
//
//   channel | direction | ports                         | payload
//   req     | in        | req_valid/req_ready/req_data  | req_payload_type
//   rsp     | out       | rsp_valid/rsp_ready/rsp_data  | rsp_payload_type
//   csr     | in        | csr_valid/csr_ready/csr_index/csr_data | 16-bit limit
//
// One item per cycle sustained while rsp is not stalled; a req transfer reaches
// rsp_valid through the input register, then the result register.
// The state machines and counter update when an item moves from the input
// register into the result register.
// A stalled rsp holds the result register; the input register keeps taking
// one more item, then req_ready drops.
// Synchronous reset restores idle/ready states, zero counter and default limits.
// ----------------------------------------------------------------------------
module gate_relay_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  grs_pkg::req_payload_type       req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output grs_pkg::rsp_payload_type       rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [grs_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [grs_pkg::LimitW-1:0]     csr_data
);

   logic                       in_valid_ff, in_valid_in;
   grs_pkg::req_payload_type   in_data_ff;
   logic                       out_valid_ff, out_valid_in;
   grs_pkg::rsp_payload_type   out_data_ff, out_data_in;
   logic [grs_pkg::CountW-1:0] count_ff, count_in;
   logic [grs_pkg::LimitW-1:0] open_time_ff, close_time_ff, cooldown_ff;

   logic                       step;
   logic                       req_xfer;
   grs_pkg::cmd_type           cmd;
   grs_pkg::press_type         press;
   grs_pkg::gate_event_type    gate_event;
   grs_pkg::relay_type         relay;
   logic [1:0]                 gate_phase;
   logic [1:0]                 button_phase;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // command counts only with a packet
   assign cmd = in_data_ff.packet_received ? grs_pkg::cmd_type'(in_data_ff.command)
                                           : grs_pkg::CMD_NOOP;

   grs_button_fsm u_button (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .now_ms       (in_data_ff.now_ms),
      .open_low     (!in_data_ff.open_button_level),
      .close_low    (!in_data_ff.close_button_level),
      .cooldown_ms  (cooldown_ff),
      .press        (press),
      .button_phase (button_phase)
   );

   assign gate_event.open_req  = press.open_pressed || (cmd == grs_pkg::CMD_OPEN);
   assign gate_event.close_req = press.close_pressed || (cmd == grs_pkg::CMD_CLOSE);

   grs_gate_fsm u_gate (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .now_ms        (in_data_ff.now_ms),
      .gate_event    (gate_event),
      .open_time_ms  (open_time_ff),
      .close_time_ms (close_time_ff),
      .relay         (relay),
      .gate_phase    (gate_phase)
   );

   always_comb begin
      count_in = count_ff + (in_data_ff.packet_received ? 8'd1 : 8'd0);
      out_data_in.relay_open_on  = relay.relay_open_on;
      out_data_in.relay_close_on = relay.relay_close_on;
      out_data_in.gate_phase     = gate_phase;
      out_data_in.button_phase   = button_phase;
      out_data_in.packet_count   = count_in;
      out_data_in.ack_due        = in_data_ff.packet_received;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   // limit registers; unknown index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         open_time_ff  <= grs_pkg::OpenTimeReset;
         close_time_ff <= grs_pkg::CloseTimeReset;
         cooldown_ff   <= grs_pkg::CooldownReset;
      end else if (csr_valid) begin
         case (grs_pkg::csr_index_type'(csr_index))
            grs_pkg::CSR_OPEN_TIME:  open_time_ff  <= csr_data;
            grs_pkg::CSR_CLOSE_TIME: close_time_ff <= csr_data;
            grs_pkg::CSR_COOLDOWN:   cooldown_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> sv/grs_checker.sv
// ----------------------------------------------------------------------------
// grs_checker: port-level checks for the gate relay sequencer
// Tracks delivered results and checks relay, counter and handshake behavior.
// ----------------------------------------------------------------------------
module grs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input grs_pkg::rsp_payload_type       rsp_data
);

   logic [1:0]                 prev_phase_ff;
   logic [grs_pkg::CountW-1:0] prev_count_ff;
   logic                       rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // remember the last delivered gate phase and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phase_ff <= grs_pkg::GATE_IDLE;
         prev_count_ff <= '0;
      end else if (rsp_xfer) begin
         prev_phase_ff <= rsp_data.gate_phase;
         prev_count_ff <= rsp_data.packet_count;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_relays_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.relay_open_on && rsp_data.relay_close_on))
      else $error("both relays energized");

   a_relay_prior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.relay_open_on == (prev_phase_ff == grs_pkg::GATE_OPENING) &&
         rsp_data.relay_close_on == (prev_phase_ff == grs_pkg::GATE_CLOSING))
      else $error("relay drive does not follow previous gate phase");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.packet_count == (prev_count_ff + (rsp_data.ack_due ? 8'd1 : 8'd0)))
      else $error("packet counter did not advance by the acknowledged packet");

endmodule

bind gate_relay_sequencer_top grs_checker u_grs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> test/tb_gate_relay_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gate_relay_sequencer_top: self-checking bench for the gate relay sequencer
// Drives control-loop passes with random gaps and response stalls. A scoreboard
// class tracks the gate, button and packet state and compares every result
// transfer field by field. The limits are reprogrammed between phases.
// ----------------------------------------------------------------------------
import grs_pkg::*;

class gate_pass_scoreboard;
   logic [LimitW-1:0] open_limit;
   logic [LimitW-1:0] close_limit;
   logic [LimitW-1:0] cooldown_limit;
   gate_state_type    gate;
   logic [TimeW-1:0]  gate_since;
   button_state_type  button;
   logic [TimeW-1:0]  button_since;
   logic [CountW-1:0] packets;
   rsp_payload_type   expected_q[$];
   int                mismatches;

   function new();
      open_limit     = OpenTimeReset;
      close_limit    = CloseTimeReset;
      cooldown_limit = CooldownReset;
      gate           = GATE_IDLE;
      gate_since     = '0;
      button         = BTN_READY;
      button_since   = '0;
      packets        = '0;
      mismatches     = 0;
   endfunction

   function void set_limit(logic [CsrIdxW-1:0] idx, logic [LimitW-1:0] value);
      if (idx == CSR_OPEN_TIME) open_limit = value;
      else if (idx == CSR_CLOSE_TIME) close_limit = value;
      else if (idx == CSR_COOLDOWN) cooldown_limit = value;
   endfunction

   function bit elapsed_reached(logic [TimeW-1:0] now, logic [TimeW-1:0] start,
                                logic [LimitW-1:0] limit);
      logic [TimeW-1:0] elapsed;
      elapsed = now - start;
      return elapsed >= {{(TimeW-LimitW){1'b0}}, limit};
   endfunction

   // advance both machines by one pass and queue the result it produces
   function void note_request(req_payload_type pass);
      cmd_type           cmd;
      bit                open_pressed;
      bit                close_pressed;
      bit                any_event;
      gate_state_type    prior;
      logic [LimitW-1:0] limit;
      rsp_payload_type   result;
      cmd           = pass.packet_received ? cmd_type'(pass.command) : CMD_NOOP;
      open_pressed  = 1'b0;
      close_pressed = 1'b0;
      prior         = gate;
      if (button == BTN_OPEN || button == BTN_CLOSE) begin
         if (elapsed_reached(pass.now_ms, button_since, cooldown_limit)) begin
            button       = BTN_READY;
            button_since = pass.now_ms;
         end
      end else if (!pass.open_button_level) begin
         button       = BTN_OPEN;
         button_since = pass.now_ms;
         open_pressed = 1'b1;
      end else if (!pass.close_button_level) begin
         button        = BTN_CLOSE;
         button_since  = pass.now_ms;
         close_pressed = 1'b1;
      end
      if (pass.packet_received) packets = packets + 1'b1;
      any_event = open_pressed || close_pressed || cmd == CMD_OPEN || cmd == CMD_CLOSE;
      if (gate == GATE_OPENING || gate == GATE_CLOSING) begin
         limit = (gate == GATE_OPENING) ? open_limit : close_limit;
         if (elapsed_reached(pass.now_ms, gate_since, limit) || any_event) begin
            gate       = GATE_IDLE;
            gate_since = pass.now_ms;
         end
      end else if (open_pressed || cmd == CMD_OPEN) begin
         gate       = GATE_OPENING;
         gate_since = pass.now_ms;
      end else if (close_pressed || cmd == CMD_CLOSE) begin
         gate       = GATE_CLOSING;
         gate_since = pass.now_ms;
      end else begin
         gate = GATE_IDLE;
      end
      result.relay_open_on  = (prior == GATE_OPENING);
      result.relay_close_on = (prior == GATE_CLOSING);
      result.gate_phase     = gate;
      result.button_phase   = button;
      result.packet_count   = packets;
      result.ack_due        = pass.packet_received;
      expected_q.push_back(result);
   endfunction

   function void check_response(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result transfer %h", got);
         return;
      end
      want = expected_q.pop_front();
      if (got.relay_open_on !== want.relay_open_on ||
          got.relay_close_on !== want.relay_close_on ||
          got.gate_phase !== want.gate_phase ||
          got.button_phase !== want.button_phase ||
          got.packet_count !== want.packet_count ||
          got.ack_due !== want.ack_due) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result mismatch: exp open %0b close %0b gate %0d btn %0d cnt %0d ack %0b",
                     want.relay_open_on, want.relay_close_on, want.gate_phase,
                     want.button_phase, want.packet_count, want.ack_due,
                     "\n                 got open %0b close %0b gate %0d btn %0d cnt %0d ack %0b",
                     got.relay_open_on, got.relay_close_on, got.gate_phase,
                     got.button_phase, got.packet_count, got.ack_due);
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function int failures();
      return mismatches + expected_q.size();
   endfunction
endclass

module tb_gate_relay_sequencer_top;

   localparam logic [CsrIdxW-1:0] CsrUnmapped = 2'd3;
   localparam int StallLimit     = 2000;
   localparam int PhaseCount     = 14;
   localparam int PassesPerPhase = 125;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_payload_type     req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_payload_type     rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [LimitW-1:0]   csr_data = '0;

   gate_pass_scoreboard sb;
   bit                  idle_on = 1'b1;
   logic [TimeW-1:0]    now_cursor = '0;
   int                  stall_cycles = 0;

   gate_relay_sequencer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   task automatic send_request(input req_payload_type pass);
      while (idle_on && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pass;
      do @(posedge clock); while (!req_ready);
      sb.note_request(pass);
   endtask

   task automatic send_pass(input logic [TimeW-1:0] now, input logic open_level,
                            input logic close_level, input logic packet,
                            input cmd_type cmd);
      req_payload_type pass;
      pass.now_ms             = now;
      pass.open_button_level  = open_level;
      pass.close_button_level = close_level;
      pass.packet_received    = packet;
      pass.command            = cmd;
      send_request(pass);
   endtask

   // hold valid low, let every result drain, then wait with the pipeline idle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIdxW-1:0] idx,
                                 input logic [LimitW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_limit(idx, value);
   endtask

   task automatic program_limits(input logic [LimitW-1:0] open_ms,
                                 input logic [LimitW-1:0] close_ms,
                                 input logic [LimitW-1:0] cool_ms);
      write_register(CSR_OPEN_TIME, open_ms);
      write_register(CSR_CLOSE_TIME, close_ms);
      write_register(CSR_COOLDOWN, cool_ms);
      // unmapped index must leave all limits untouched
      write_register(CsrUnmapped, LimitW'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   function automatic req_payload_type random_pass();
      req_payload_type pass;
      int unsigned     roll;
      int unsigned     span;
      span = 32'(sb.open_limit);
      if (sb.close_limit > span) span = 32'(sb.close_limit);
      if (sb.cooldown_limit > span) span = 32'(sb.cooldown_limit);
      roll = $urandom_range(0, 99);
      if (roll < 55) now_cursor += $urandom_range(0, 8);
      else if (roll < 88) now_cursor += $urandom_range(0, span + span / 2 + 1);
      else if (roll < 96) now_cursor += $urandom_range(0, 140000);
      else now_cursor = $urandom;
      pass.now_ms = now_cursor;
      if ($urandom_range(0, 99) < 5) begin
         pass.open_button_level  = 1'($urandom_range(0, 1));
         pass.close_button_level = 1'($urandom_range(0, 1));
      end else begin
         pass.open_button_level  = ($urandom_range(0, 99) >= 12);
         pass.close_button_level = ($urandom_range(0, 99) >= 12);
      end
      pass.packet_received = ($urandom_range(0, 99) < 30);
      pass.command         = 2'($urandom_range(0, 3));
      return pass;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         rsp_ready <= !(idle_on && $urandom_range(0, 99) < 10);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= StallLimit) begin
            $display("gate_relay_sequencer_top: mismatch");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned roll;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default limits: open 20000, close 15000, cooldown 1000
      send_pass(32'd0, 1'b1, 1'b1, 1'b0, CMD_OPEN);          // command without packet
      send_pass(32'd5, 1'b0, 1'b0, 1'b0, CMD_NOOP);          // both pressed, open wins
      send_pass(32'd10, 1'b1, 1'b1, 1'b1, CMD_PING);
      send_pass(32'd2000, 1'b1, 1'b1, 1'b1, CMD_NOOP);       // cooldown ends
      send_pass(32'd20005, 1'b1, 1'b1, 1'b0, CMD_NOOP);      // open times out
      send_pass(32'd20010, 1'b1, 1'b0, 1'b0, CMD_NOOP);      // close press
      send_pass(32'd20020, 1'b1, 1'b1, 1'b1, CMD_OPEN);      // command stops motion
      send_pass(32'd20030, 1'b1, 1'b1, 1'b1, CMD_CLOSE);
      send_pass(32'd21100, 1'b1, 1'b1, 1'b0, CMD_NOOP);
      send_pass(32'd35030, 1'b1, 1'b0, 1'b0, CMD_NOOP);      // timeout and press together
      send_pass(32'd35031, 1'b1, 1'b1, 1'b1, CMD_OPEN);
      send_pass(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, CMD_PING);
      send_pass(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, CMD_CLOSE); // press beats command
      send_pass(32'h0000_0010, 1'b1, 1'b1, 1'b0, CMD_PING);  // elapsed across the wrap
      send_pass(32'h0000_4E1F, 1'b1, 1'b1, 1'b0, CMD_NOOP);
      drain();
      program_limits('0, '0, '0);
      send_pass(32'd100, 1'b0, 1'b1, 1'b0, CMD_NOOP);
      send_pass(32'd100, 1'b1, 1'b1, 1'b0, CMD_NOOP);        // zero limits expire at once
      send_pass(32'd101, 1'b1, 1'b0, 1'b1, CMD_OPEN);
      send_pass(32'd101, 1'b1, 1'b1, 1'b1, CMD_CLOSE);
      drain();
      program_limits('1, '1, '1);
      send_pass(32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1, CMD_NOOP);
      send_pass(32'hAAAB_AAA9, 1'b1, 1'b1, 1'b0, CMD_PING);
      send_pass(32'h5555_5555, 1'b1, 1'b0, 1'b1, CMD_PING);
      send_pass(32'h5555_5556, 1'b1, 1'b1, 1'b1, CMD_CLOSE);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         drain();
         idle_on = !(phase == 6 || phase == 7);
         roll = $urandom_range(0, 99);
         if (phase == 0) program_limits('0, '0, '0);
         else if (phase == 1) program_limits('1, '1, '1);
         else if (roll < 50)
            program_limits(LimitW'($urandom_range(0, 40)), LimitW'($urandom_range(0, 40)),
                           LimitW'($urandom_range(0, 40)));
         else if (roll < 75)
            program_limits(LimitW'($urandom_range(0, 2000)), LimitW'($urandom_range(0, 2000)),
                           LimitW'($urandom_range(0, 2000)));
         else
            program_limits(LimitW'($urandom_range(0, 65535)),
                           LimitW'($urandom_range(0, 65535)),
                           LimitW'($urandom_range(0, 65535)));
         if ($urandom_range(0, 99) < 30) now_cursor = 32'hFFFF_FFFF - $urandom_range(0, 300);
         for (int n = 0; n < PassesPerPhase; n++) send_request(random_pass());
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.failures() == 0) begin
         $display("gate_relay_sequencer_top: match");
      end else begin
         $display("gate_relay_sequencer_top: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/grs_pkg.sv
sv/grs_button_fsm.sv
sv/grs_gate_fsm.sv
sv/gate_relay_sequencer_top.sv
sv/grs_checker.sv
test/tb_gate_relay_sequencer_top.sv
